@@ rtl/core/pvt_derating_factor_interpolator_macros.svh @@
// Assertion macros shared by the derating interpolator RTL.
// Each macro samples on clk and is switched off while rst is high.
`ifndef PVT_DERATING_FACTOR_INTERPOLATOR_MACROS_SVH
`define PVT_DERATING_FACTOR_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVTDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the delay dly after the antecedent.
`define PVTDF_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pvtdf_pkg.sv @@
package pvtdf_pkg;

  localparam int VOLT_POINTS   = 7;
  localparam int TEMP_POINTS   = 15;
  localparam int FRACTION_BITS = 16;

  localparam int FIX_W   = 17;
  localparam int VOLT_W  = 11;
  localparam int TEMP_W  = 12;
  localparam int PROC_W  = 3;
  localparam int VSEG_W  = $clog2(VOLT_POINTS);
  localparam int TSEG_W  = $clog2(TEMP_POINTS);
  localparam int DIFF_W  = FIX_W + 1;
  localparam int VOFF_W  = 6;
  localparam int TOFF_W  = 8;
  localparam int VPROD_W = DIFF_W + VOFF_W + 1;
  localparam int TPROD_W = DIFF_W + TOFF_W + 1;
  localparam int VMAG_W  = VPROD_W - 1;
  localparam int TMAG_W  = TPROD_W - 1;

  // Division by a segment width is a multiply by a rounded-up reciprocal.
  // Products stay below 2^20, so with a 32-bit shift the quotient is exact.
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 27;
  localparam int VQ_W        = VMAG_W + RECIP_W - RECIP_SHIFT;
  localparam int TQ_W        = TMAG_W + RECIP_W - RECIP_SHIFT;
  localparam int SUM_W       = TQ_W + 1;

  localparam logic [63:0] MICRO        = 64'd1000000;
  localparam logic [63:0] ONE_SHIFTED  = 64'd1 << RECIP_SHIFT;
  localparam logic [63:0] VOLT_STEP    = 64'd40;
  localparam logic [63:0] TEMP_STEP_S  = 64'd100;
  localparam logic [63:0] TEMP_STEP_L  = 64'd150;

  localparam logic [RECIP_W-1:0] VOLT_RECIP =
    RECIP_W'((ONE_SHIFTED + VOLT_STEP - 64'd1) / VOLT_STEP);
  localparam logic [RECIP_W-1:0] TEMP_RECIP_S =
    RECIP_W'((ONE_SHIFTED + TEMP_STEP_S - 64'd1) / TEMP_STEP_S);
  localparam logic [RECIP_W-1:0] TEMP_RECIP_L =
    RECIP_W'((ONE_SHIFTED + TEMP_STEP_L - 64'd1) / TEMP_STEP_L);

  // Millionths to fixed point, rounding halves up.
  function automatic logic [FIX_W-1:0] to_fixed(input logic [31:0] micro);
    logic [63:0] v;
    v = ({32'd0, micro} << FRACTION_BITS) + (MICRO >> 1);
    return FIX_W'(v / MICRO);
  endfunction

  localparam logic [VOLT_W-1:0] VOLT_X [VOLT_POINTS] = '{
    11'd1080, 11'd1120, 11'd1160, 11'd1200, 11'd1240, 11'd1280, 11'd1320
  };

  localparam logic [FIX_W-1:0] VOLT_Y_FX [VOLT_POINTS] = '{
    to_fixed(32'd1121557), to_fixed(32'd1075332), to_fixed(32'd1035161),
    to_fixed(32'd1000000), to_fixed(32'd968480),  to_fixed(32'd940065),
    to_fixed(32'd914482)
  };

  localparam logic signed [TEMP_W-1:0] TEMP_X [TEMP_POINTS] = '{
    -12'sd250, -12'sd150, 12'sd0,    12'sd150,  12'sd250,
    12'sd350,  12'sd450,  12'sd550,  12'sd650,  12'sd750,
    12'sd850,  12'sd950,  12'sd1050, 12'sd1150, 12'sd1250
  };

  localparam logic [FIX_W-1:0] TEMP_Y_FX [TEMP_POINTS] = '{
    to_fixed(32'd897498),  to_fixed(32'd917532),  to_fixed(32'd948338),
    to_fixed(32'd979213),  to_fixed(32'd1000000), to_fixed(32'd1020305),
    to_fixed(32'd1040540), to_fixed(32'd1061831), to_fixed(32'd1082983),
    to_fixed(32'd1103817), to_fixed(32'd1124124), to_fixed(32'd1144245),
    to_fixed(32'd1164563), to_fixed(32'd1184370), to_fixed(32'd1204966)
  };

  // Reciprocal of each temperature segment width, segment by segment.
  localparam logic [RECIP_W-1:0] TEMP_RECIP [TEMP_POINTS-1] = '{
    TEMP_RECIP_S, TEMP_RECIP_L, TEMP_RECIP_L, TEMP_RECIP_S, TEMP_RECIP_S,
    TEMP_RECIP_S, TEMP_RECIP_S, TEMP_RECIP_S, TEMP_RECIP_S, TEMP_RECIP_S,
    TEMP_RECIP_S, TEMP_RECIP_S, TEMP_RECIP_S, TEMP_RECIP_S
  };

  localparam logic [FIX_W-1:0] PROC_Y_FX [3] = '{
    to_fixed(32'd1174235), to_fixed(32'd1000000), to_fixed(32'd876148)
  };

  localparam logic [PROC_W-1:0] CORNER_FAST = 3'd1;
  localparam logic [PROC_W-1:0] CORNER_SLOW = 3'd3;

  typedef struct packed {
    logic             vv;
    logic             tv;
    logic             pv;
    logic [FIX_W-1:0] pf;
  } pass_t;

endpackage

@@ rtl/core/pvt_derating_factor_interpolator.sv @@
// An accepted transaction passes through the register stages below, and its result
// shows with done high once the final add stage has registered it.
// Throughput: one transaction per cycle; busy is always low and nothing stalls.
// The five register stages are segment search, table lookup, slope multiply,
// reciprocal multiply and final add.
// Reset clears the stage valid bits and done; data registers are not reset.
`include "pvt_derating_factor_interpolator_macros.svh"

module pvt_derating_factor_interpolator
  import pvtdf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [VOLT_W-1:0]        voltage_mv,
  input  logic signed [TEMP_W-1:0] temperature_tenths,
  input  logic [PROC_W-1:0]        process_corner,
  output logic                     done,
  output logic [FIX_W-1:0]         voltage_factor,
  output logic [FIX_W-1:0]         temperature_factor,
  output logic [FIX_W-1:0]         process_factor,
  output logic                     voltage_valid,
  output logic                     temperature_valid,
  output logic                     process_valid
);

  // Stage valid bits
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  // Stage 1: segment search
  logic [VOLT_W-1:0]        s1_volt;
  logic signed [TEMP_W-1:0] s1_temp;
  logic [VSEG_W-1:0]        s1_vseg;
  logic [TSEG_W-1:0]        s1_tseg;
  pass_t                    s1_pass;
  logic [VSEG_W-1:0]        vseg_next;
  logic [TSEG_W-1:0]        tseg_next;
  pass_t                    pass_next;

  // Stage 2: offsets and table values
  logic [VOFF_W-1:0]        s2_voff;
  logic [TOFF_W-1:0]        s2_toff;
  logic signed [DIFF_W-1:0] s2_vdiff, s2_tdiff;
  logic [FIX_W-1:0]         s2_vy1, s2_ty1;
  logic [RECIP_W-1:0]       s2_trecip;
  pass_t                    s2_pass;
  logic [VOLT_W-1:0]        voff_full;
  logic signed [TEMP_W-1:0] toff_full;

  // Stage 3: slope times offset, as sign and magnitude
  logic [VMAG_W-1:0]        s3_vmag;
  logic [TMAG_W-1:0]        s3_tmag;
  logic                     s3_vneg, s3_tneg;
  logic [FIX_W-1:0]         s3_vy1, s3_ty1;
  logic [RECIP_W-1:0]       s3_trecip;
  pass_t                    s3_pass;
  logic signed [VPROD_W-1:0] vprod;
  logic signed [TPROD_W-1:0] tprod;

  // Stage 4: quotients
  logic [VQ_W-1:0]          s4_vq;
  logic [TQ_W-1:0]          s4_tq;
  logic                     s4_vneg, s4_tneg;
  logic [FIX_W-1:0]         s4_vy1, s4_ty1;
  pass_t                    s4_pass;
  logic [VMAG_W+RECIP_W-1:0] vq_full;
  logic [TMAG_W+RECIP_W-1:0] tq_full;

  // Final sums
  logic signed [SUM_W-1:0]  vsum, tsum;

  assign busy = 1'b0;

  always_comb begin
    vseg_next = '0;
    tseg_next = '0;
    for (int i = 1; i < VOLT_POINTS - 1; i++) begin
      if (voltage_mv >= VOLT_X[i]) vseg_next = VSEG_W'(i);
    end
    for (int i = 1; i < TEMP_POINTS - 1; i++) begin
      if (temperature_tenths >= TEMP_X[i]) tseg_next = TSEG_W'(i);
    end
    pass_next.vv = (voltage_mv >= VOLT_X[0]) && (voltage_mv <= VOLT_X[VOLT_POINTS-1]);
    pass_next.tv = (temperature_tenths >= TEMP_X[0]) &&
                   (temperature_tenths <= TEMP_X[TEMP_POINTS-1]);
    pass_next.pv = process_corner inside {[CORNER_FAST:CORNER_SLOW]};
    pass_next.pf = pass_next.pv ? PROC_Y_FX[2'(process_corner - CORNER_FAST)] : '0;
  end

  always_ff @(posedge clk) begin
    s1_volt <= voltage_mv;
    s1_temp <= temperature_tenths;
    s1_vseg <= vseg_next;
    s1_tseg <= tseg_next;
    s1_pass <= pass_next;
  end

  // The last breakpoint falls in the final segment with a full-width offset,
  // which lands exactly on its table value.
  assign voff_full = s1_volt - VOLT_X[s1_vseg];
  assign toff_full = s1_temp - TEMP_X[s1_tseg];

  always_ff @(posedge clk) begin
    s2_voff   <= voff_full[VOFF_W-1:0];
    s2_toff   <= toff_full[TOFF_W-1:0];
    s2_vdiff  <= $signed({1'b0, VOLT_Y_FX[s1_vseg + VSEG_W'(1)]}) -
                 $signed({1'b0, VOLT_Y_FX[s1_vseg]});
    s2_tdiff  <= $signed({1'b0, TEMP_Y_FX[s1_tseg + TSEG_W'(1)]}) -
                 $signed({1'b0, TEMP_Y_FX[s1_tseg]});
    s2_vy1    <= VOLT_Y_FX[s1_vseg];
    s2_ty1    <= TEMP_Y_FX[s1_tseg];
    s2_trecip <= TEMP_RECIP[s1_tseg];
    s2_pass   <= s1_pass;
  end

  assign vprod = s2_vdiff * $signed({1'b0, s2_voff});
  assign tprod = s2_tdiff * $signed({1'b0, s2_toff});

  always_ff @(posedge clk) begin
    s3_vneg   <= vprod[VPROD_W-1];
    s3_tneg   <= tprod[TPROD_W-1];
    s3_vmag   <= vprod[VPROD_W-1] ? VMAG_W'(-vprod) : VMAG_W'(vprod);
    s3_tmag   <= tprod[TPROD_W-1] ? TMAG_W'(-tprod) : TMAG_W'(tprod);
    s3_vy1    <= s2_vy1;
    s3_ty1    <= s2_ty1;
    s3_trecip <= s2_trecip;
    s3_pass   <= s2_pass;
  end

  // Dividing the magnitude truncates toward zero once the sign is put back.
  assign vq_full = s3_vmag * VOLT_RECIP;
  assign tq_full = s3_tmag * s3_trecip;

  always_ff @(posedge clk) begin
    s4_vq   <= vq_full[VMAG_W+RECIP_W-1:RECIP_SHIFT];
    s4_tq   <= tq_full[TMAG_W+RECIP_W-1:RECIP_SHIFT];
    s4_vneg <= s3_vneg;
    s4_tneg <= s3_tneg;
    s4_vy1  <= s3_vy1;
    s4_ty1  <= s3_ty1;
    s4_pass <= s3_pass;
  end

  assign vsum = s4_vneg ? (SUM_W'(s4_vy1) - SUM_W'(s4_vq)) : (SUM_W'(s4_vy1) + SUM_W'(s4_vq));
  assign tsum = s4_tneg ? (SUM_W'(s4_ty1) - SUM_W'(s4_tq)) : (SUM_W'(s4_ty1) + SUM_W'(s4_tq));

  always_ff @(posedge clk) begin
    voltage_valid      <= s4_pass.vv;
    temperature_valid  <= s4_pass.tv;
    process_valid      <= s4_pass.pv;
    process_factor     <= s4_pass.pf;
    voltage_factor     <= (s4_pass.vv && !vsum[SUM_W-1]) ? vsum[FIX_W-1:0] : '0;
    temperature_factor <= (s4_pass.tv && !tsum[SUM_W-1]) ? tsum[FIX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      done     <= s4_valid;
    end
  end

  `PVTDF_ASSERT_DLY(a_latency, start && !busy, 5, done, "result transaction missing")
  `PVTDF_ASSERT_IMP(a_volt_span, done && voltage_valid,
    (voltage_factor <= VOLT_Y_FX[0]) && (voltage_factor >= VOLT_Y_FX[VOLT_POINTS-1]),
    "voltage factor outside table span")
  `PVTDF_ASSERT_IMP(a_temp_span, done && temperature_valid,
    (temperature_factor >= TEMP_Y_FX[0]) && (temperature_factor <= TEMP_Y_FX[TEMP_POINTS-1]),
    "temperature factor outside table span")
  `PVTDF_ASSERT_IMP(a_proc_value, done && process_valid,
    (process_factor == PROC_Y_FX[0]) || (process_factor == PROC_Y_FX[1]) ||
    (process_factor == PROC_Y_FX[2]), "process factor not a corner value")

endmodule

@@ tb/pvtdf_result_checker.sv @@
module pvtdf_result_checker
  import pvtdf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [VOLT_W-1:0]        voltage_mv,
  input  logic signed [TEMP_W-1:0] temperature_tenths,
  input  logic [PROC_W-1:0]        process_corner,
  input  logic                     done,
  input  logic [FIX_W-1:0]         voltage_factor,
  input  logic [FIX_W-1:0]         temperature_factor,
  input  logic [FIX_W-1:0]         process_factor,
  input  logic                     voltage_valid,
  input  logic                     temperature_valid,
  input  logic                     process_valid,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [FIX_W-1:0] vf;
    logic [FIX_W-1:0] tf;
    logic [FIX_W-1:0] pf;
    logic             vv;
    logic             tv;
    logic             pv;
  } derating_t;

  // Breakpoints in millivolts and tenths of a degree, factors in millionths; unused tail entries are padding.
  localparam int N_VOLT = 7;
  localparam int N_TEMP = 15;
  localparam int VOLT_MV [16] = '{1080, 1120, 1160, 1200, 1240, 1280, 1320,
                                  0, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam int VOLT_PPM [16] = '{1121557, 1075332, 1035161, 1000000, 968480,
                                   940065, 914482, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam int TEMP_DC [16] = '{-250, -150, 0, 150, 250, 350, 450, 550, 650,
                                  750, 850, 950, 1050, 1150, 1250, 0};
  localparam int TEMP_PPM [16] = '{897498, 917532, 948338, 979213, 1000000,
                                   1020305, 1040540, 1061831, 1082983, 1103817,
                                   1124124, 1144245, 1164563, 1184370, 1204966,
                                   0};
  localparam int CORNER_PPM [3] = '{1174235, 1000000, 876148};

  derating_t factor_q[$];

  // Millionths to Q1.16 with halves rounded up.
  function automatic longint ppm_to_q16(input int ppm);
    longint unsigned scaled;
    scaled = (longint'(ppm) << 16) + 64'd500000;
    return longint'(scaled / 64'd1000000);
  endfunction

  function automatic void piecewise(input int x, input int xs [16], input int ys [16],
                                    input int n, output logic ok,
                                    output logic [FIX_W-1:0] f);
    longint y1, y2, v;
    ok = 1'b0;
    f = '0;
    if (x < xs[0] || x > xs[n-1]) return;
    for (int i = 0; i < n; i++) begin
      if (x == xs[i]) begin
        ok = 1'b1;
        f = FIX_W'(ppm_to_q16(ys[i]));
        return;
      end
    end
    for (int i = 0; i < n - 1; i++) begin
      if (x > xs[i] && x < xs[i+1]) begin
        y1 = ppm_to_q16(ys[i]);
        y2 = ppm_to_q16(ys[i+1]);
        // Signed longint division truncates toward zero.
        v = y1 + ((y2 - y1) * longint'(x - xs[i])) / longint'(xs[i+1] - xs[i]);
        if (v < 0) v = 0;
        ok = 1'b1;
        f = FIX_W'(v);
        return;
      end
    end
  endfunction

  function automatic derating_t predict_factors(input int volt, input int temp,
                                                input int corner);
    derating_t d;
    piecewise(volt, VOLT_MV, VOLT_PPM, N_VOLT, d.vv, d.vf);
    piecewise(temp, TEMP_DC, TEMP_PPM, N_TEMP, d.tv, d.tf);
    d.pv = (corner >= 1 && corner <= 3);
    d.pf = d.pv ? FIX_W'(ppm_to_q16(CORNER_PPM[corner-1])) : '0;
    return d;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Inputs and outputs only move at rising edges, so the values seen at the
  // falling edge are the ones taken at the next rising edge.
  always @(negedge clk) begin
    derating_t want;
    if (!rst) begin
      if (done) begin
        if (factor_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no transaction outstanding, vf %0d tf %0d pf %0d",
                   $time, voltage_factor, temperature_factor, process_factor);
        end else begin
          want = factor_q.pop_front();
          check_field("voltage_factor", want.vf, voltage_factor);
          check_field("temperature_factor", want.tf, temperature_factor);
          check_field("process_factor", want.pf, process_factor);
          check_field("voltage_valid", want.vv, voltage_valid);
          check_field("temperature_valid", want.tv, temperature_valid);
          check_field("process_valid", want.pv, process_valid);
        end
      end
      if (start && !busy)
        factor_q.push_back(predict_factors(int'(voltage_mv), int'(temperature_tenths),
                                           int'(process_corner)));
    end
    pending = factor_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top
  import pvtdf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 1000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [VOLT_W-1:0]        voltage_mv = '0;
  logic signed [TEMP_W-1:0] temperature_tenths = '0;
  logic [PROC_W-1:0]        process_corner = '0;
  logic                     done;
  logic [FIX_W-1:0]         voltage_factor;
  logic [FIX_W-1:0]         temperature_factor;
  logic [FIX_W-1:0]         process_factor;
  logic                     voltage_valid;
  logic                     temperature_valid;
  logic                     process_valid;
  int                       fail_count;
  int                       pending;
  int                       idle_cycles = 0;

  pvt_derating_factor_interpolator u_top (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .voltage_mv         (voltage_mv),
    .temperature_tenths (temperature_tenths),
    .process_corner     (process_corner),
    .done               (done),
    .voltage_factor     (voltage_factor),
    .temperature_factor (temperature_factor),
    .process_factor     (process_factor),
    .voltage_valid      (voltage_valid),
    .temperature_valid  (temperature_valid),
    .process_valid      (process_valid)
  );

  pvtdf_result_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .voltage_mv         (voltage_mv),
    .temperature_tenths (temperature_tenths),
    .process_corner     (process_corner),
    .done               (done),
    .voltage_factor     (voltage_factor),
    .temperature_factor (temperature_factor),
    .process_factor     (process_factor),
    .voltage_valid      (voltage_valid),
    .temperature_valid  (temperature_valid),
    .process_valid      (process_valid),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Issues one transaction, then idles for a random gap unless gaps are off.
  task automatic issue(input int v, input int t, input int c, input bit no_gaps);
    int  gap;
    int  r;
    logic stalled;
    start              <= 1'b1;
    voltage_mv         <= VOLT_W'(v);
    temperature_tenths <= TEMP_W'(t);
    process_corner     <= PROC_W'(c);
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int  v;
    int  t;
    int  c;
    bit  burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Field extremes (the lowest temperature tried is -1024), table edges, breakpoints, both slopes and every corner.
    issue(0,    -1024, 0, 0);
    issue(2047,  2047, 7, 0);
    issue(1079,  -251, 4, 0);
    issue(1080,  -250, 1, 0);
    issue(1081,  -249, 2, 0);
    issue(1100,  -200, 3, 0);
    issue(1120,  -150, 5, 0);
    issue(1139,    -1, 6, 0);
    issue(1160,     0, 1, 0);
    issue(1199,     1, 2, 0);
    issue(1200,   149, 3, 0);
    issue(1201,   150, 1, 0);
    issue(1240,   250, 2, 0);
    issue(1279,   349, 3, 0);
    issue(1280,  1249, 1, 0);
    issue(1319,  1250, 2, 0);
    issue(1320,  1251, 3, 0);
    issue(1321,     0, 1, 0);
    issue(1200,   700, 2, 0);
    issue(1024,    -1, 3, 0);
    issue(1300,  2000, 0, 0);
    issue(1111,  1234, 7, 0);

    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1:    v = $urandom_range(0, 2047);
        2, 3:    v = 1080 + 40 * int'($urandom_range(0, 6)) + int'($urandom_range(0, 4)) - 2;
        default: v = $urandom_range(1080, 1320);
      endcase
      case ($urandom_range(0, 9))
        0, 1:    t = int'($urandom_range(0, 3071)) - 1024;
        2, 3:    t = 50 * int'($urandom_range(0, 30)) - 250 + int'($urandom_range(0, 2)) - 1;
        default: t = int'($urandom_range(0, 1500)) - 250;
      endcase
      c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
      issue(v, t, c, burst);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS pvt_derating_factor_interpolator");
    end else begin
      $display("FAIL pvt_derating_factor_interpolator");
    end
    $finish;
  end

  // Ends the run when no transaction and no result moves for too long.
  always @(negedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL pvt_derating_factor_interpolator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pvtdf_pkg.sv
rtl/core/pvt_derating_factor_interpolator.sv
tb/pvtdf_result_checker.sv
tb/tb_top.sv
